// ----- sv/swst_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths, status codes and helpers for the seed window sorted table.
// No dependencies; every other file in this folder imports this package.
package swst_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = IDX_W + 1;
    localparam int RPOS_W  = 16;
    localparam int GPOS_W  = 34;
    localparam int LEN_W   = 16;
    localparam int LOG_W   = $clog2(LEN_W);
    localparam int SCORE_W = LEN_W + 1;
    localparam int STAT_W  = 4;
    localparam int CFG_W   = 7;

    localparam logic [STAT_W-1:0] ST_INSERTED = 4'd0;
    localparam logic [STAT_W-1:0] ST_EVICTED  = 4'd1;
    localparam logic [STAT_W-1:0] ST_REPLACED = 4'd2;
    localparam logic [STAT_W-1:0] ST_KEPT     = 4'd3;
    localparam logic [STAT_W-1:0] ST_DUP      = 4'd4;
    localparam logic [STAT_W-1:0] ST_SHORT    = 4'd5;
    localparam logic [STAT_W-1:0] ST_ANCHORS  = 4'd6;
    localparam logic [STAT_W-1:0] ST_TOOSHORT = 4'd7;
    localparam logic [STAT_W-1:0] ST_READ     = 4'd8;

    localparam logic [LEN_W-1:0] UNSET_MIN = '1;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef struct packed {
        logic [RPOS_W-1:0]  read_start;
        logic [GPOS_W-1:0]  genome_start;
        logic [LEN_W-1:0]   length;
        logic [SCORE_W-1:0] score;
        logic               anchor;
    } entry_t;

    typedef struct packed {
        logic               func;
        logic [RPOS_W-1:0]  seed_read_start;
        logic [GPOS_W-1:0]  seed_genome_start;
        logic [LEN_W-1:0]   seed_length;
        logic               seed_anchor;
        logic [IDX_W-1:0]   slot_index;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [RPOS_W-1:0]  entry_read_start;
        logic [GPOS_W-1:0]  entry_genome_start;
        logic [LEN_W-1:0]   entry_length;
        logic [SCORE_W-1:0] entry_score;
        logic               entry_anchor;
        logic [CNT_W-1:0]   entry_count;
        logic [CNT_W-1:0]   anchor_count;
        logic [LEN_W-1:0]   full_min_length;
    } out_t;

    typedef struct packed {
        logic load_seed;
        logic take_left;
        logic take_right;
    } cell_ctrl_t;

    function automatic logic [LOG_W-1:0] floor_log2(input logic [LEN_W-1:0] v);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 0; i < LEN_W; i++)
        begin
            if (v[i])
            begin
                r = LOG_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [SCORE_W-1:0] seed_score(input logic [LEN_W-1:0] len);
        logic [SCORE_W-1:0] s;
        if (len == '0)
        begin
            s = '0;
        end
        else
        begin
            s = SCORE_W'(len) + SCORE_W'(floor_log2(len));
        end
        return s;
    endfunction

endpackage

// ----- sv/seed_window_sorted_table.sv -----
`timescale 1ns / 1ps
// Top level of the seed window sorted table: control sequencer plus a row of slot cells.
// Depends on swst_pkg and swst_cell.
//
//   channel   direction  handshake              payload
//   seed      in         seed_valid/seed_stall  seed_data   (swst_pkg::in_t)
//   result    out        result_valid/result_stall result_data (swst_pkg::out_t)
//   cfg       in         cfg_we (no wait)       cfg_data    (max_seeds)
//
// One transaction at a time. A read or a short-ignored insert goes from decode to the
// result; other inserts check for overlaps first. A duplicate or a kept overlap ends
// there; a replaced overlap removes the old slot and then inserts. An insert into a full
// table runs a bit-serial minimum search over the non-anchor slot lengths, one bit per
// cycle, then is rejected as too short or evicts; an all-anchor table is rejected at once.
// The next transaction can be accepted in the cycle after the result register loads.
// Reset clears the counts and the remembered minimum; slot contents are not cleared.
// A stalled result holds in the output register; a following result waits in S_FIN.
module seed_window_sorted_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seed_valid,
    output logic              seed_stall,
    input  swst_pkg::in_t     seed_data,
    output logic              result_valid,
    input  logic              result_stall,
    output swst_pkg::out_t    result_data,
    input  logic              cfg_we,
    input  logic [swst_pkg::CFG_W-1:0] cfg_data
);
    import swst_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_OVL    = 4'd2;
    localparam logic [3:0] S_HIT    = 4'd3;
    localparam logic [3:0] S_MIN    = 4'd4;
    localparam logic [3:0] S_MINF   = 4'd5;
    localparam logic [3:0] S_REM    = 4'd6;
    localparam logic [3:0] S_INS    = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [CFG_W-1:0]   max_reg;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   anch_reg, anch_next;
    logic [LEN_W-1:0]   min_reg, min_next;
    entry_t             seed_reg;
    logic               func_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [STAT_W-1:0]  st_reg, st_next;
    entry_t             rd_reg, rd_next;
    logic [IDX_W-1:0]   hit_reg, hit_next;
    logic [IDX_W-1:0]   rm_reg, rm_next;
    logic [DEPTH-1:0]   ovl_reg;
    logic [DEPTH-1:0]   cand_reg, cand_next;
    logic [LOG_W-1:0]   bit_reg, bit_next;
    logic               res_valid_reg;
    out_t               res_data_reg;

    entry_t             entry_q [DEPTH];
    entry_t             left_q  [DEPTH];
    entry_t             right_q [DEPTH];
    cell_ctrl_t         ctrl    [DEPTH];
    logic [DEPTH-1:0]   ovl_c;
    logic [DEPTH-1:0]   le_c;
    logic [DEPTH-1:0]   valid_v;
    logic [DEPTH-1:0]   le_v;
    logic [DEPTH-1:0]   nonanc_v;
    logic [DEPTH-1:0]   lenbit_v;
    logic [DEPTH-1:0]   zeros_v;
    logic [IDX_W-1:0]   ovl_first;
    logic [IDX_W-1:0]   cand_first;
    logic [CNT_W-1:0]   cap;
    logic               full;
    logic               out_free;
    logic               accept;
    entry_t             hit_e;
    entry_t             rm_e;
    entry_t             min_e;

    // Row of slot cells; each hands its entry to both neighbors.
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_l0
            assign left_q[k] = entry_q[k];
        end
        else
        begin : g_ln
            assign left_q[k] = entry_q[k-1];
        end
        if (k == DEPTH - 1)
        begin : g_rl
            assign right_q[k] = entry_q[k];
        end
        else
        begin : g_rn
            assign right_q[k] = entry_q[k+1];
        end

        assign valid_v[k]  = (CNT_W'(k) < used_reg);
        assign le_v[k]     = le_c[k] & valid_v[k];
        assign nonanc_v[k] = valid_v[k] & ~entry_q[k].anchor;
        assign lenbit_v[k] = entry_q[k].length[bit_reg];

        // Insert shift: slots past the sorted position take from the left.
        always_comb
        begin
            ctrl[k].load_seed  = 1'b0;
            ctrl[k].take_left  = 1'b0;
            ctrl[k].take_right = 1'b0;
            if (state_reg == S_INS && !le_v[k])
            begin
                if (k == 0)
                begin
                    ctrl[k].load_seed = 1'b1;
                end
                else if (le_v[(k == 0) ? 0 : k-1])
                begin
                    ctrl[k].load_seed = 1'b1;
                end
                else
                begin
                    ctrl[k].take_left = 1'b1;
                end
            end
            // Remove shift: close the gap at the removed slot.
            if (state_reg == S_REM && IDX_W'(k) >= rm_reg)
            begin
                ctrl[k].take_right = 1'b1;
            end
        end

        swst_cell u_cell (
            .clk         (clk),
            .seed        (seed_reg),
            .left_entry  (left_q[k]),
            .right_entry (right_q[k]),
            .ctrl        (ctrl[k]),
            .entry       (entry_q[k]),
            .overlap     (ovl_c[k]),
            .le          (le_c[k])
        );
    end

    // First set bit of the overlap and candidate vectors.
    always_comb
    begin
        ovl_first  = '0;
        cand_first = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (ovl_reg[i])
            begin
                ovl_first = IDX_W'(i);
            end
            if (cand_reg[i])
            begin
                cand_first = IDX_W'(i);
            end
        end
    end

    assign cap      = (max_reg > CFG_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(max_reg);
    assign full     = (used_reg >= cap);
    assign out_free = !res_valid_reg || !result_stall;
    assign accept   = seed_valid && !seed_stall;
    assign hit_e    = entry_q[hit_reg];
    assign rm_e     = entry_q[rm_reg];
    assign min_e    = entry_q[cand_first];
    assign zeros_v  = cand_reg & ~lenbit_v;

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        anch_next  = anch_reg;
        min_next   = min_reg;
        st_next    = st_reg;
        rd_next    = rd_reg;
        hit_next   = hit_reg;
        rm_next    = rm_reg;
        cand_next  = cand_reg;
        bit_next   = bit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                rd_next = '0;
                if (func_reg == FUNC_READ)
                begin
                    st_next = ST_READ;
                    if (valid_v[slot_reg])
                    begin
                        rd_next = entry_q[slot_reg];
                    end
                    state_next = S_FIN;
                end
                else if (!seed_reg.anchor && min_reg != UNSET_MIN
                         && seed_reg.length < min_reg)
                begin
                    st_next    = ST_SHORT;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_OVL;
                end
            end
            S_OVL:
            begin
                if (|ovl_reg)
                begin
                    hit_next   = ovl_first;
                    state_next = S_HIT;
                end
                else if (full)
                begin
                    if (nonanc_v == '0)
                    begin
                        min_next   = UNSET_MIN;
                        st_next    = ST_ANCHORS;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cand_next  = nonanc_v;
                        bit_next   = LOG_W'(LEN_W - 1);
                        state_next = S_MIN;
                    end
                end
                else
                begin
                    st_next    = ST_INSERTED;
                    state_next = S_INS;
                end
            end
            S_HIT:
            begin
                if (hit_e.genome_start == seed_reg.genome_start
                    && hit_e.length == seed_reg.length)
                begin
                    st_next    = ST_DUP;
                    state_next = S_FIN;
                end
                else if (seed_reg.length > hit_e.length)
                begin
                    rm_next    = hit_reg;
                    st_next    = ST_REPLACED;
                    state_next = S_REM;
                end
                else
                begin
                    st_next    = ST_KEPT;
                    state_next = S_FIN;
                end
            end
            S_MIN:
            begin
                // Drop candidates with a one where some candidate has a zero.
                if (|zeros_v)
                begin
                    cand_next = zeros_v;
                end
                if (bit_reg == '0)
                begin
                    state_next = S_MINF;
                end
                else
                begin
                    bit_next = bit_reg - LOG_W'(1);
                end
            end
            S_MINF:
            begin
                min_next = min_e.length;
                if (!seed_reg.anchor && min_e.length >= seed_reg.length)
                begin
                    st_next    = ST_TOOSHORT;
                    state_next = S_FIN;
                end
                else
                begin
                    rm_next    = cand_first;
                    st_next    = ST_EVICTED;
                    state_next = S_REM;
                end
            end
            S_REM:
            begin
                used_next = used_reg - CNT_W'(1);
                if (rm_e.anchor)
                begin
                    anch_next = anch_reg - CNT_W'(1);
                end
                state_next = S_INS;
            end
            S_INS:
            begin
                used_next = used_reg + CNT_W'(1);
                if (seed_reg.anchor)
                begin
                    anch_next = anch_reg + CNT_W'(1);
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_reg       <= CFG_W'(DEPTH);
            used_reg      <= '0;
            anch_reg      <= '0;
            min_reg       <= UNSET_MIN;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            anch_reg  <= anch_next;
            min_reg   <= min_next;
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
            if (state_reg == S_FIN && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        rd_reg   <= rd_next;
        hit_reg  <= hit_next;
        rm_reg   <= rm_next;
        cand_reg <= cand_next;
        bit_reg  <= bit_next;
        if (state_reg == S_DECODE)
        begin
            ovl_reg <= ovl_c & valid_v;
        end
        if (accept)
        begin
            func_reg              <= seed_data.func;
            slot_reg              <= seed_data.slot_index;
            seed_reg.read_start   <= seed_data.seed_read_start;
            seed_reg.genome_start <= seed_data.seed_genome_start;
            seed_reg.length       <= seed_data.seed_length;
            seed_reg.score        <= seed_score(seed_data.seed_length);
            seed_reg.anchor       <= seed_data.seed_anchor;
        end
        if (state_reg == S_FIN && out_free)
        begin
            res_data_reg.status             <= st_reg;
            res_data_reg.entry_read_start   <= rd_reg.read_start;
            res_data_reg.entry_genome_start <= rd_reg.genome_start;
            res_data_reg.entry_length       <= rd_reg.length;
            res_data_reg.entry_score        <= rd_reg.score;
            res_data_reg.entry_anchor       <= rd_reg.anchor;
            res_data_reg.entry_count        <= used_reg;
            res_data_reg.anchor_count       <= anch_reg;
            res_data_reg.full_min_length    <= min_reg;
        end
    end

    assign seed_stall   = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result_data  = res_data_reg;

endmodule

// ----- sv/swst_cell.sv -----
`timescale 1ns / 1ps
// One table slot: holds an entry, tests it against the current seed, shifts with neighbors.
// Depends on swst_pkg.
module swst_cell (
    input  logic                clk,
    input  swst_pkg::entry_t    seed,
    input  swst_pkg::entry_t    left_entry,
    input  swst_pkg::entry_t    right_entry,
    input  swst_pkg::cell_ctrl_t ctrl,
    output swst_pkg::entry_t    entry,
    output logic                overlap,
    output logic                le
);
    import swst_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    logic [GPOS_W:0]  diag_a;
    logic [GPOS_W:0]  diag_b;
    logic [RPOS_W:0]  e_end;
    logic [RPOS_W:0]  s_end;
    logic [RPOS_W:0]  e_rs;
    logic [RPOS_W:0]  s_rs;
    logic             start_in;
    logic             end_in;

    always_comb
    begin
        diag_a   = (GPOS_W+1)'(seed.genome_start) + (GPOS_W+1)'(entry_reg.read_start);
        diag_b   = (GPOS_W+1)'(entry_reg.genome_start) + (GPOS_W+1)'(seed.read_start);
        e_rs     = (RPOS_W+1)'(entry_reg.read_start);
        s_rs     = (RPOS_W+1)'(seed.read_start);
        e_end    = e_rs + (RPOS_W+1)'(entry_reg.length);
        s_end    = s_rs + (RPOS_W+1)'(seed.length);
        start_in = (s_rs >= e_rs) && (s_rs < e_end);
        end_in   = (s_end > e_rs) && (s_end <= e_end);
        overlap  = (diag_a == diag_b) && (start_in || end_in);
        le       = (entry_reg.read_start <= seed.read_start);
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load_seed)
        begin
            entry_next = seed;
        end
        else if (ctrl.take_left)
        begin
            entry_next = left_entry;
        end
        else if (ctrl.take_right)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- sv/swst_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the seed window sorted table, bound to the top level.
// Depends on swst_pkg and seed_window_sorted_table.
module swst_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              result_valid,
    input  logic              result_stall,
    input  swst_pkg::out_t    result_data
);
    import swst_pkg::*;

    // Hold a stalled result.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.entry_count <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_anchor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.anchor_count <= result_data.entry_count)
        else $error("more anchors than entries");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status != ST_READ |->
            result_data.entry_length == '0 && result_data.entry_score == '0
            && result_data.entry_anchor == 1'b0)
        else $error("entry fields set on insert");

endmodule

bind seed_window_sorted_table swst_checker u_swst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

// ----- test/seed_window_sorted_table_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for seed_window_sorted_table: random and directed seed inserts and
// slot reads, checked against a behavioral table predictor. Depends on swst_pkg and the RTL.
module seed_window_sorted_table_test;
    import swst_pkg::*;

    logic clk;
    logic rst_n;
    logic seed_valid;
    logic seed_stall;
    in_t seed_data;
    logic result_valid;
    logic result_stall;
    out_t result_data;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_data;

    seed_window_sorted_table uut (
        .clk(clk),
        .rst_n(rst_n),
        .seed_valid(seed_valid),
        .seed_stall(seed_stall),
        .seed_data(seed_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    // Predictor copy of the table state
    logic [RPOS_W-1:0] tbl_rs [DEPTH];
    logic [GPOS_W-1:0] tbl_gs [DEPTH];
    logic [LEN_W-1:0] tbl_len [DEPTH];
    logic [SCORE_W-1:0] tbl_score [DEPTH];
    logic tbl_anc [DEPTH];
    int held;
    int anchors;
    logic [LEN_W-1:0] full_min;
    int limit_seeds;

    in_t pending_items[$];
    out_t expected_results[$];
    int failures;
    int gap_left;
    int stall_left;
    bit hold_off;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Append one item to the pending queue
    function automatic void queue_item(input in_t s);
        pending_items = {pending_items, s};
    endfunction

    function automatic int log2_floor(input int v);
        int r;
        r = 0;
        while (v > 1)
        begin
            v = v >> 1;
            r++;
        end
        return r;
    endfunction

    function automatic void drop_slot(input int p);
        if (tbl_anc[p])
        begin
            anchors--;
        end
        for (int k = p; k + 1 < held; k++)
        begin
            tbl_rs[k] = tbl_rs[k+1];
            tbl_gs[k] = tbl_gs[k+1];
            tbl_len[k] = tbl_len[k+1];
            tbl_score[k] = tbl_score[k+1];
            tbl_anc[k] = tbl_anc[k+1];
        end
        held--;
    endfunction

    function automatic void place_seed(input in_t s);
        int pos;
        pos = 0;
        if (held >= DEPTH)
        begin
            return;
        end
        while (pos < held && tbl_rs[pos] <= s.seed_read_start)
        begin
            pos++;
        end
        for (int k = held; k > pos; k--)
        begin
            tbl_rs[k] = tbl_rs[k-1];
            tbl_gs[k] = tbl_gs[k-1];
            tbl_len[k] = tbl_len[k-1];
            tbl_score[k] = tbl_score[k-1];
            tbl_anc[k] = tbl_anc[k-1];
        end
        tbl_rs[pos] = s.seed_read_start;
        tbl_gs[pos] = s.seed_genome_start;
        tbl_len[pos] = s.seed_length;
        tbl_score[pos] = (s.seed_length == 0) ? '0 :
            SCORE_W'(s.seed_length) + SCORE_W'(log2_floor(s.seed_length));
        tbl_anc[pos] = s.seed_anchor;
        held++;
        if (s.seed_anchor)
        begin
            anchors++;
        end
    endfunction

    function automatic logic [STAT_W-1:0] insert_outcome(input in_t s);
        logic [17:0] send;
        logic [17:0] eend;
        logic [GPOS_W+1:0] lhs;
        logic [GPOS_W+1:0] rhs;
        int cap;
        int best;
        int rm;
        send = 18'(s.seed_read_start) + 18'(s.seed_length);
        if (!s.seed_anchor && full_min != UNSET_MIN && s.seed_length < full_min)
        begin
            return ST_SHORT;
        end
        for (int i = 0; i < held; i++)
        begin
            eend = 18'(tbl_rs[i]) + 18'(tbl_len[i]);
            lhs = (GPOS_W+2)'(s.seed_genome_start) + (GPOS_W+2)'(tbl_rs[i]);
            rhs = (GPOS_W+2)'(tbl_gs[i]) + (GPOS_W+2)'(s.seed_read_start);
            if (lhs == rhs && ((s.seed_read_start >= tbl_rs[i] && 18'(s.seed_read_start) < eend)
                || (send > 18'(tbl_rs[i]) && send <= eend)))
            begin
                if (s.seed_genome_start == tbl_gs[i] && s.seed_length == tbl_len[i])
                begin
                    return ST_DUP;
                end
                if (s.seed_length > tbl_len[i])
                begin
                    drop_slot(i);
                    place_seed(s);
                    return ST_REPLACED;
                end
                return ST_KEPT;
            end
        end
        cap = (limit_seeds > DEPTH) ? DEPTH : limit_seeds;
        if (held >= cap)
        begin
            best = 32'h7FFF_FFFF;
            rm = -1;
            for (int i = 0; i < held; i++)
            begin
                if (!tbl_anc[i] && tbl_len[i] < best)
                begin
                    best = tbl_len[i];
                    rm = i;
                end
            end
            if (rm < 0)
            begin
                full_min = UNSET_MIN;
                return ST_ANCHORS;
            end
            full_min = LEN_W'(best);
            if (!s.seed_anchor && best >= s.seed_length)
            begin
                return ST_TOOSHORT;
            end
            drop_slot(rm);
            place_seed(s);
            return ST_EVICTED;
        end
        place_seed(s);
        return ST_INSERTED;
    endfunction

    function automatic out_t predict_result(input in_t s);
        out_t r;
        r = '0;
        if (s.func == FUNC_READ)
        begin
            r.status = ST_READ;
            if (s.slot_index < held)
            begin
                r.entry_read_start = tbl_rs[s.slot_index];
                r.entry_genome_start = tbl_gs[s.slot_index];
                r.entry_length = tbl_len[s.slot_index];
                r.entry_score = tbl_score[s.slot_index];
                r.entry_anchor = tbl_anc[s.slot_index];
            end
        end
        else
        begin
            r.status = insert_outcome(s);
        end
        r.entry_count = CNT_W'(held);
        r.anchor_count = CNT_W'(anchors);
        r.full_min_length = full_min;
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(0, 3);
    endfunction

    // Driver: present the head of the pending queue, hold it while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            seed_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (seed_valid && !seed_stall)
            begin
                expected_results = {expected_results, predict_result(seed_data)};
            end
            if (seed_valid && seed_stall)
            begin
                // hold the stalled transaction
            end
            else if (gap_left > 0)
            begin
                seed_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0 && !hold_off)
            begin
                seed_data <= pending_items.pop_front();
                seed_valid <= 1'b1;
                gap_left <= pick_gap();
            end
            else
            begin
                seed_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        out_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                        result_data);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want !== result_data)
                    begin
                        $display("%0t: mismatch, expected %h, actual %h", $time, want,
                            result_data);
                        failures++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                stall_left <= pick_gap();
                result_stall <= 1'b0;
            end
        end
    end

    function automatic in_t make_seed(input int rs, input longint gs, input int len,
        input bit anc);
        in_t s;
        s = '0;
        s.func = FUNC_INSERT;
        s.seed_read_start = RPOS_W'(rs);
        s.seed_genome_start = GPOS_W'(gs);
        s.seed_length = LEN_W'(len);
        s.seed_anchor = anc;
        s.slot_index = IDX_W'($urandom);
        return s;
    endfunction

    function automatic in_t make_read(input int slot);
        in_t s;
        s = '0;
        s.func = FUNC_READ;
        s.seed_read_start = RPOS_W'($urandom);
        s.seed_genome_start = {2'($urandom), 32'($urandom)};
        s.seed_length = LEN_W'($urandom);
        s.seed_anchor = 1'($urandom);
        s.slot_index = IDX_W'(slot);
        return s;
    endfunction

    // Random read or seed; seeds mostly lie on eight diagonals so that overlaps happen
    function automatic in_t random_item(input int span);
        int rs;
        int len;
        longint diag;
        in_t s;
        if ($urandom_range(0, 4) == 0)
        begin
            return make_read($urandom_range(0, 63));
        end
        rs = $urandom_range(0, span);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 60);
        if ($urandom_range(0, 9) == 0)
        begin
            diag = {2'($urandom), 32'($urandom)};
        end
        else
        begin
            diag = 64'($urandom_range(0, 3)) * 1000 + 64'h3_0000_0000 * $urandom_range(0, 1);
        end
        s = make_seed(rs, diag + rs, len, $urandom_range(0, 5) == 0);
        if ($urandom_range(0, 15) == 0)
        begin
            s.seed_read_start = RPOS_W'($urandom);
        end
        return s;
    endfunction

    task automatic drain_and_idle();
        @(negedge clk);
        while (pending_items.size() > 0 || seed_valid || expected_results.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (30) @(posedge clk);
    endtask

    task automatic write_limit(input int v);
        drain_and_idle();
        cfg_data <= CFG_W'(v);
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_seeds = v;
    endtask

    initial
    begin
        int settings[6];
        rst_n = 1'b0;
        seed_valid = 1'b0;
        seed_data = '0;
        result_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        hold_off = 1'b0;
        failures = 0;
        held = 0;
        anchors = 0;
        full_min = UNSET_MIN;
        limit_seeds = 64;
        settings = '{4, 1, 0, 127, 64, 17};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: small table, overlap cases, full-table cases, extremes
        write_limit(3);
        queue_item(make_read(0));
        queue_item(make_seed(100, 5100, 20, 0));
        queue_item(make_seed(100, 5100, 20, 0));
        queue_item(make_seed(110, 5110, 5, 0));
        queue_item(make_seed(95, 5095, 30, 0));
        queue_item(make_seed(0, 0, 0, 0));
        queue_item(make_seed(95, 999, 10, 1));
        queue_item(make_seed(95, 888, 12, 0));
        queue_item(make_seed(65535, 64'h3_FFFF_FFFF, 65535, 1));
        queue_item(make_seed(7, 77, 2, 0));
        queue_item(make_seed(8, 88, 1, 0));
        queue_item(make_seed(9, 99, 65535, 1));
        queue_item(make_seed(9, 199, 65535, 1));
        for (int i = 0; i < 4; i++)
        begin
            queue_item(make_read(i));
        end
        queue_item(make_read(63));
        write_limit(0);
        queue_item(make_seed(1, 1, 1, 0));
        queue_item(make_seed(2, 2, 2, 1));

        // Random phases over several table limits
        for (int ph = 0; ph < 6; ph++)
        begin
            write_limit(settings[ph]);
            for (int n = 0; n < 190; n++)
            begin
                queue_item(random_item(ph == 3 ? 65535 : 400));
                if (n == 95 && ph == 2)
                begin
                    // pause the sender with one item left until every result is back
                    while (pending_items.size() > 1)
                    begin
                        @(negedge clk);
                    end
                    hold_off = 1'b1;
                    @(negedge clk);
                    while (seed_valid || expected_results.size() > 0)
                    begin
                        @(negedge clk);
                    end
                    repeat (20) @(negedge clk);
                    hold_off = 1'b0;
                end
            end
        end
        drain_and_idle();
        if (failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/swst_pkg.sv
sv/swst_cell.sv
sv/seed_window_sorted_table.sv
sv/swst_checker.sv
test/seed_window_sorted_table_test.sv
